// ===== hw/rtl/sqrt_pkg.sv =====
// Shared types and constants for the square root core.
// No dependencies.
package sqrt_pkg;

	typedef enum logic [1:0] {
		FUNC_INT32   = 2'd0,
		FUNC_INT64   = 2'd1,
		FUNC_INT_FIX = 2'd2,
		FUNC_FIX_FIX = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ITER,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic step_en;
		logic out_load;
	} ctrl_t;

	localparam logic [63:0] INT_BIT_INIT   = 64'h4000_0000_0000_0000;
	localparam logic [31:0] FIX_BIT_INIT   = 32'h4000_0000;
	localparam logic [31:0] FRAC_BIT_INIT  = 32'h2000_0000;
	localparam logic [31:0] FRAC_ROUND     = 32'h0000_0040;
	localparam int          FRAC_SHIFT     = 7;
	localparam int          FRAC_LSB_POS   = 15;
	localparam int          FRAC_LAST_BIT  = 5;

endpackage

// ===== hw/rtl/integer_and_fixed_point_sqrt_core.sv =====
// Square root core: integer floor roots (32 and 64 bit) and rounded 16.16 roots.
// Depends on sqrt_pkg.
//
// One word is taken when in_ready is high; the core then works on it alone
// and drops in_ready until the result is loaded into the output register.
// A single 64-bit compare-and-subtract unit decides one root bit per cycle.
// The loop decides 32 root bits for func 0 and 1, 31 for func 2 and 25 for
// func 3; it starts on the cycle after the accept, and a rounding state
// follows it. The next word is accepted the cycle after the result is
// loaded, even if the result is still waiting on out_ready.
module integer_and_fixed_point_sqrt_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sqrt_pkg::func_t func,
	input  logic [63:0]     value,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     root
);
	import sqrt_pkg::*;

	state_t      state_q, state_n;
	ctrl_t       ctrl;
	func_t       func_q;
	logic [63:0] rem_q, acc_q, bit_q;
	logic        out_valid_q;
	logic [31:0] root_q;

	logic        fix;
	logic        last;
	logic [63:0] trial_w, cmp_trial;
	logic [64:0] diff;
	logic        ge;
	logic [31:0] fix_acc, fix_rem, round_sum;
	logic [31:0] root_n;

	assign fix       = func_q[1];
	assign last      = (func_q == FUNC_FIX_FIX) ? bit_q[FRAC_LAST_BIT] : bit_q[0];
	assign trial_w   = acc_q + bit_q;
	assign cmp_trial = fix ? {32'b0, trial_w[31:0]} : trial_w;
	assign diff      = {1'b0, rem_q} - {1'b0, cmp_trial};
	assign ge        = ~diff[64];
	assign fix_acc   = ge ? (trial_w[31:0] + bit_q[31:0]) : acc_q[31:0];
	assign fix_rem   = ge ? diff[31:0] : rem_q[31:0];
	assign round_sum = acc_q[31:0] + FRAC_ROUND;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_n = ST_ITER;
			end
			ST_ITER: begin
				if (last)
					state_n = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready)
					state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: ctrl.in_ready = 1'b1;
			ST_ITER: ctrl.step_en  = 1'b1;
			ST_DONE: ctrl.out_load = !out_valid_q || out_ready;
			default: ctrl = '0;
		endcase
	end

	// final rounding (the integer functions pass the floor root through)
	always_comb begin
		case (func_q)
			FUNC_INT32, FUNC_INT64: root_n = acc_q[31:0];
			FUNC_INT_FIX: root_n = (rem_q[31:0] > acc_q[31:0]) ?
				acc_q[31:0] + 32'd1 : acc_q[31:0];
			FUNC_FIX_FIX: root_n = round_sum >> FRAC_SHIFT;
			default: root_n = acc_q[31:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctrl.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.in_ready && in_valid) begin
			func_q <= func;
			case (func)
				FUNC_INT32: begin
					rem_q <= {32'b0, value[31:0]};
					acc_q <= '0;
					bit_q <= INT_BIT_INIT;
				end
				FUNC_INT64: begin
					rem_q <= value;
					acc_q <= '0;
					bit_q <= INT_BIT_INIT;
				end
				FUNC_INT_FIX: begin
					rem_q <= {32'b0, value[31:0]};
					acc_q <= '0;
					bit_q <= {32'b0, FIX_BIT_INIT};
				end
				FUNC_FIX_FIX: begin
					rem_q <= {33'b0, value[31:1]};
					acc_q <= {32'b0, 32'(value[0]) << FRAC_LSB_POS};
					bit_q <= {32'b0, FRAC_BIT_INIT};
				end
				default: begin
					rem_q <= value;
					acc_q <= '0;
					bit_q <= INT_BIT_INIT;
				end
			endcase
		end else if (ctrl.step_en) begin
			if (fix) begin
				rem_q <= {32'b0, fix_rem << 1};
				acc_q <= {32'b0, fix_acc};
				bit_q <= bit_q >> 1;
			end else begin
				rem_q <= ge ? diff[63:0] : rem_q;
				acc_q <= (acc_q >> 1) | (ge ? bit_q : 64'b0);
				bit_q <= bit_q >> 2;
			end
		end
		if (ctrl.out_load)
			root_q <= root_n;
	end

	assign in_ready  = ctrl.in_ready;
	assign out_valid = out_valid_q;
	assign root      = root_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for integer_and_fixed_point_sqrt_core: random and directed radicands in all four
// functions, checked word by word against a scoreboard with its own root predictor.
// Depends on sqrt_pkg and the core RTL.
module testbench;
	import sqrt_pkg::*;

	localparam int unsigned ITEMS        = 1500;
	localparam int unsigned HOLD_AT      = 150;
	localparam int unsigned HOLD_CYCLES  = 500;
	localparam int unsigned DRAIN_CYCLES = 80;
	localparam int unsigned CYCLE_LIMIT  = 400_000;

	typedef struct {
		func_t       op;
		logic [63:0] radicand;
		logic [31:0] root;
	} root_due_t;

	class sqrt_scoreboard;
		root_due_t   due_q[$];
		int unsigned bad;

		function new();
			bad = 0;
		endfunction

		function logic [31:0] root_of(func_t op, logic [63:0] v);
			logic [63:0] r, a, b, t;
			logic [31:0] r32, a32, b32, t32;
			case (op)
				FUNC_INT32, FUNC_INT64: begin
					r = (op == FUNC_INT64) ? v : {32'b0, v[31:0]};
					a = '0;
					b = INT_BIT_INIT;
					while (b > r)
						b = b >> 2;
					while (b != 0) begin
						t = a + b;
						a = a >> 1;
						if (r >= t) begin
							r = r - t;
							a = a + b;
						end
						b = b >> 2;
					end
					return a[31:0];
				end
				FUNC_INT_FIX: begin
					if (v[31:0] == 0)
						return '0;
					r32 = v[31:0];
					a32 = '0;
					b32 = FIX_BIT_INIT;
					while (b32 != 0) begin
						t32 = a32 + b32;
						if (r32 >= t32) begin
							r32 = r32 - t32;
							a32 = t32 + b32;
						end
						r32 = r32 << 1;
						b32 = b32 >> 1;
					end
					if (r32 > a32)
						a32 = a32 + 1;
					return a32;
				end
				default: begin
					r32 = v[31:0] >> 1;
					a32 = 32'(v[0]) << FRAC_LSB_POS;
					b32 = FRAC_BIT_INIT;
					do begin
						t32 = a32 + b32;
						if (r32 >= t32) begin
							r32 = r32 - t32;
							a32 = t32 + b32;
						end
						b32 = b32 >> 1;
						r32 = r32 << 1;
					end while (b32 > 32'h10);
					t32 = a32 + FRAC_ROUND;
					return t32 >> FRAC_SHIFT;
				end
			endcase
		endfunction

		function void note_input(func_t op, logic [63:0] v);
			root_due_t due;
			due.op = op;
			due.radicand = v;
			due.root = root_of(op, v);
			due_q.push_back(due);
		endfunction

		function void check_result(logic [31:0] got);
			root_due_t due;
			if (due_q.size() == 0) begin
				bad++;
				if (bad <= 10)
					$display("unexpected root %h with no word outstanding", got);
				return;
			end
			due = due_q.pop_front();
			if (got !== due.root) begin
				bad++;
				if (bad <= 10)
					$display("mismatch: func %s value %h expected %h got %h",
						due.op.name(), due.radicand, due.root, got);
			end
		endfunction

		function int unsigned pending();
			return due_q.size();
		endfunction

		function int unsigned failures();
			return bad + due_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	func_t       func = FUNC_INT32;
	logic [63:0] value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] root;

	bit             steady = 1'b0;
	int unsigned    cycles = 0;
	sqrt_scoreboard sb = new();

	integer_and_fixed_point_sqrt_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.root      (root)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("integer_and_fixed_point_sqrt_core test failed");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(root);

	task automatic offer_word(input func_t op, input logic [63:0] v);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= op;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_input(op, v);
	endtask

	function automatic logic [63:0] pick_radicand(func_t op);
		logic [63:0] v, sq;
		logic [31:0] r;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: ;
			1: v = v >> $urandom_range(0, 63);
			2: begin
				r = (op == FUNC_INT64) ? $urandom : $urandom_range(0, 16'hFFFF);
				sq = {32'b0, r} * {32'b0, r};
				sq = sq + 64'($urandom_range(0, 2)) - 64'd1;
				v = (op == FUNC_INT64) ? sq : {v[63:32], sq[31:0]};
			end
			default: begin
				case ($urandom_range(0, 3))
					0: v[31:0] = '0;
					1: v[31:0] = 32'hFFFF_FFFF;
					2: v[31:0] = 32'h1 << $urandom_range(0, 31);
					default: v = (op == FUNC_INT64) ? '1 : {v[63:32], 32'h8000_0000};
				endcase
			end
		endcase
		return v;
	endfunction

	initial begin
		int unsigned taken;
		int unsigned stall;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == HOLD_AT)
				stall = HOLD_CYCLES;
			else
				stall = steady ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin
		func_t op;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_word(FUNC_INT32, 64'h0);
		offer_word(FUNC_INT32, 64'h1);
		offer_word(FUNC_INT32, 64'hFFFF_FFFF_FFFF_FFFF);
		offer_word(FUNC_INT32, 64'hDEAD_BEEF_0000_0010);
		offer_word(FUNC_INT32, 64'h0000_0000_FFFE_0001);
		offer_word(FUNC_INT64, 64'h0);
		offer_word(FUNC_INT64, 64'h1);
		offer_word(FUNC_INT64, 64'hFFFF_FFFF_FFFF_FFFF);
		offer_word(FUNC_INT64, 64'hFFFF_FFFE_0000_0001);
		offer_word(FUNC_INT64, 64'hFFFF_FFFE_0000_0000);
		offer_word(FUNC_INT_FIX, 64'h0);
		offer_word(FUNC_INT_FIX, 64'hFFFF_FFFF_0000_0000);
		offer_word(FUNC_INT_FIX, 64'h1);
		offer_word(FUNC_INT_FIX, 64'h0000_0000_8000_0000);
		offer_word(FUNC_INT_FIX, 64'hFFFF_FFFF_FFFF_FFFF);
		offer_word(FUNC_INT_FIX, 64'h0000_0000_0001_0000);
		offer_word(FUNC_FIX_FIX, 64'h0);
		offer_word(FUNC_FIX_FIX, 64'h1);
		offer_word(FUNC_FIX_FIX, 64'h0000_0000_0001_0000);
		offer_word(FUNC_FIX_FIX, 64'hFFFF_FFFF_FFFF_FFFF);
		offer_word(FUNC_FIX_FIX, 64'h0000_0000_7FFF_FFFF);
		offer_word(FUNC_FIX_FIX, 64'h1234_5678_0000_0002);

		for (int unsigned n = 0; n < ITEMS; n++) begin
			steady = (n >= 300 && n < 450) || (n >= 1000 && n < 1100);
			op = func_t'($urandom_range(0, 3));
			offer_word(op, pick_radicand(op));
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures() == 0)
			$display("integer_and_fixed_point_sqrt_core test passed");
		else
			$display("integer_and_fixed_point_sqrt_core test failed");
		$finish;
	end

endmodule
